// ===== sv/tpwl_pkg.sv =====
// ----------------------------------------------------------------------------
// tpwl_pkg
// Shared constants, types and helpers for the torsion parameter lookup.
// ----------------------------------------------------------------------------
package tpwl_pkg;

    localparam int TORS_DEPTH   = 256;
    localparam int MACRO_DEPTH  = 16;
    localparam int MEMBER_DEPTH = 16;
    localparam int NAME_CHARS   = 7;
    localparam int NAME_W       = 56;
    localparam int TIDX_W       = $clog2(TORS_DEPTH);
    localparam int MIDX_W       = $clog2(MACRO_DEPTH);
    localparam int BIDX_W       = $clog2(MEMBER_DEPTH);

    localparam logic [7:0] CH_WILD = 8'h58;
    localparam logic [7:0] CH_UNIV = 8'h23;

    localparam logic [1:0] OP_LOAD_ENTRY  = 2'd0;
    localparam logic [1:0] OP_LOAD_MACRO  = 2'd1;
    localparam logic [1:0] OP_LOAD_MEMBER = 2'd2;
    localparam logic [1:0] OP_LOOKUP      = 2'd3;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_MACRO_COUNT = 1'b1;

    typedef struct packed {
        logic       key_rd;
        logic [1:0] key_sel;
        logic       mac_rd;
        logic       mem_rd;
        logic       clr;
        logic       par_rd;
        logic       emit;
    } tpwl_cmd_t;

    typedef struct packed {
        logic name_hit;
        logic is_univ;
        logic univ_hit;
        logic mem_hit;
        logic plain_hit;
        logic wild_ok;
    } tpwl_sts_t;

    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int k = 0; k < NAME_CHARS; k++) begin
            if (v[8*k +: 8] == 8'h00)
                live = 1'b0;
            if (live)
                r[8*k +: 8] = v[8*k +: 8];
        end
        return r;
    endfunction

endpackage

// ===== sv/tpwl_datapath.sv =====
// ----------------------------------------------------------------------------
// tpwl_datapath
// Stores, query registers and name compare logic for the torsion lookup.
// ----------------------------------------------------------------------------
module tpwl_datapath
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [1:0]                        opcode,
    input  logic [7:0]                        slot,
    input  logic [4:0]                        count_or_member,
    input  logic [tpwl_pkg::NAME_W-1:0]       name_a,
    input  logic [tpwl_pkg::NAME_W-1:0]       name_b,
    input  logic [tpwl_pkg::NAME_W-1:0]       name_c,
    input  logic [tpwl_pkg::NAME_W-1:0]       name_d,
    input  logic signed [5:0]                 mult_in,
    input  logic [31:0]                       force_in,
    input  logic [31:0]                       phase_in,
    input  logic [31:0]                       term_in,
    input  logic                              q_load,
    input  logic [tpwl_pkg::TIDX_W-1:0]       entry_idx,
    input  logic [1:0]                        atom_sel,
    input  logic [tpwl_pkg::MIDX_W-1:0]       macro_idx,
    input  logic [tpwl_pkg::BIDX_W-1:0]       member_idx,
    input  tpwl_pkg::tpwl_cmd_t               cmd,
    output tpwl_pkg::tpwl_sts_t               sts,
    output logic [4:0]                        size_out,
    output logic signed [5:0]                 mult_out,
    output logic [31:0]                       force_out,
    output logic [31:0]                       phase_out,
    output logic [31:0]                       term_out
);

    logic [4*tpwl_pkg::NAME_W-1:0] key_mem [tpwl_pkg::TORS_DEPTH];
    logic [5:0]                  mult_mem [tpwl_pkg::TORS_DEPTH];
    logic [31:0]                 force_mem [tpwl_pkg::TORS_DEPTH];
    logic [31:0]                 phase_mem [tpwl_pkg::TORS_DEPTH];
    logic [31:0]                 term_mem [tpwl_pkg::TORS_DEPTH];
    logic [tpwl_pkg::NAME_W-1:0] mname_mem [tpwl_pkg::MACRO_DEPTH];
    logic [4:0]                  msize_mem [tpwl_pkg::MACRO_DEPTH];
    logic [tpwl_pkg::NAME_W-1:0] member_mem [tpwl_pkg::MACRO_DEPTH*tpwl_pkg::MEMBER_DEPTH];

    logic [tpwl_pkg::NAME_W-1:0] q_reg [4];
    logic [tpwl_pkg::NAME_W-1:0] tname_reg;
    logic [tpwl_pkg::NAME_W-1:0] mname_reg;
    logic [4:0]                  msize_reg;
    logic [tpwl_pkg::NAME_W-1:0] member_reg;
    logic [tpwl_pkg::NAME_W-1:0] atom;
    logic [tpwl_pkg::NAME_W-1:0] na;
    logic                        slot_ok_t;
    logic                        slot_ok_m;

    assign na        = tpwl_pkg::norm_name(name_a);
    assign slot_ok_t = ({1'b0, slot} < 9'(tpwl_pkg::TORS_DEPTH));
    assign slot_ok_m = ({1'b0, slot} < 9'(tpwl_pkg::MACRO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en && opcode == tpwl_pkg::OP_LOAD_ENTRY && slot_ok_t)
        begin
            key_mem[slot[tpwl_pkg::TIDX_W-1:0]] <= {tpwl_pkg::norm_name(name_d),
                                                     tpwl_pkg::norm_name(name_c),
                                                     tpwl_pkg::norm_name(name_b),
                                                     na};
            mult_mem[slot[tpwl_pkg::TIDX_W-1:0]]  <= mult_in;
            force_mem[slot[tpwl_pkg::TIDX_W-1:0]] <= force_in;
            phase_mem[slot[tpwl_pkg::TIDX_W-1:0]] <= phase_in;
            term_mem[slot[tpwl_pkg::TIDX_W-1:0]]  <= term_in;
        end
        if (wr_en && opcode == tpwl_pkg::OP_LOAD_MACRO && slot_ok_m)
        begin
            mname_mem[slot[tpwl_pkg::MIDX_W-1:0]] <= na;
            msize_mem[slot[tpwl_pkg::MIDX_W-1:0]] <= count_or_member;
        end
        if (wr_en && opcode == tpwl_pkg::OP_LOAD_MEMBER && slot_ok_m
            && count_or_member < 5'(tpwl_pkg::MEMBER_DEPTH))
        begin
            member_mem[{slot[tpwl_pkg::MIDX_W-1:0],
                        count_or_member[tpwl_pkg::BIDX_W-1:0]}] <= na;
        end
        if (q_load)
        begin
            q_reg[0] <= na;
            q_reg[1] <= tpwl_pkg::norm_name(name_b);
            q_reg[2] <= tpwl_pkg::norm_name(name_c);
            q_reg[3] <= tpwl_pkg::norm_name(name_d);
        end
        if (cmd.key_rd)
            tname_reg <= key_mem[entry_idx][cmd.key_sel * tpwl_pkg::NAME_W +: tpwl_pkg::NAME_W];
        if (cmd.mac_rd)
        begin
            mname_reg <= mname_mem[macro_idx];
            msize_reg <= msize_mem[macro_idx];
        end
        if (cmd.mem_rd)
            member_reg <= member_mem[{macro_idx, member_idx}];
        if (cmd.par_rd)
        begin
            mult_out  <= cmd.clr ? 6'sd0 : signed'(mult_mem[entry_idx]);
            force_out <= cmd.clr ? 32'd0 : force_mem[entry_idx];
            phase_out <= cmd.clr ? 32'd0 : phase_mem[entry_idx];
            term_out  <= cmd.clr ? 32'd0 : term_mem[entry_idx];
        end
    end

    assign atom          = q_reg[atom_sel];
    assign size_out      = msize_reg;
    assign sts.name_hit  = (mname_reg == tname_reg);
    assign sts.is_univ   = (msize_reg == 5'd1) && (member_reg[15:8] == tpwl_pkg::CH_UNIV);
    assign sts.univ_hit  = (atom[7:0] == member_reg[7:0]);
    assign sts.mem_hit   = (member_reg == atom);
    assign sts.plain_hit = (atom == tname_reg);
    assign sts.wild_ok   = (tname_reg[7:0] == tpwl_pkg::CH_WILD);

endmodule

// ===== sv/tpwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpwl_ctrl
// Sequencer for loads and the two-pass, two-orientation table search.
// ----------------------------------------------------------------------------
module tpwl_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    opcode,
    input  logic [8:0]                    entry_count,
    input  logic [4:0]                    macro_count,
    input  tpwl_pkg::tpwl_sts_t           sts,
    input  logic [4:0]                    size_in,
    output logic                          busy,
    output logic                          q_load,
    output logic [tpwl_pkg::TIDX_W-1:0]   entry_idx,
    output logic [1:0]                    atom_sel,
    output logic [tpwl_pkg::MIDX_W-1:0]   macro_idx,
    output logic [tpwl_pkg::BIDX_W-1:0]   member_idx,
    output tpwl_pkg::tpwl_cmd_t           cmd,
    output logic                          done,
    output logic                          found,
    output logic [8:0]                    entry_number
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ENTRY  = 10'b0000000010,
        S_KEY    = 10'b0000000100,
        S_MAC    = 10'b0000001000,
        S_MCHK   = 10'b0000010000,
        S_MEM    = 10'b0000100000,
        S_MEMCHK = 10'b0001000000,
        S_PARAM  = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_FETCH  = 10'b1000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [8:0]                   ent_reg, ent_next;
    logic                         pass_reg, pass_next;
    logic                         rev_reg, rev_next;
    logic [1:0]                   cmp_reg, cmp_next;
    logic [4:0]                   mac_reg, mac_next;
    logic [4:0]                   mem_reg, mem_next;
    logic                         hit_reg, hit_next;
    logic [8:0]                   ncap;
    logic [4:0]                   mcap;
    logic [4:0]                   scap;
    logic [1:0]                   key_pos;
    logic                         is_outer;
    logic                         cmp_ok;
    logic                         cmp_fail;
    logic                         lookup_go;

    function automatic logic [1:0] next_atom(input logic [1:0] c);
        case (c)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            2'd2:    return 2'd0;
            default: return 2'd3;
        endcase
    endfunction

    assign ncap = (entry_count > 9'(tpwl_pkg::TORS_DEPTH)) ? 9'(tpwl_pkg::TORS_DEPTH) : entry_count;
    assign mcap = (macro_count > 5'(tpwl_pkg::MACRO_DEPTH)) ? 5'(tpwl_pkg::MACRO_DEPTH) : macro_count;
    assign scap = (size_in > 5'(tpwl_pkg::MEMBER_DEPTH)) ? 5'(tpwl_pkg::MEMBER_DEPTH) : size_in;

    // Compare order: centre b, centre c, outer a, outer d.
    always_comb
    begin
        case (cmp_reg)
            2'd0:    atom_sel = 2'd1;
            2'd1:    atom_sel = 2'd2;
            2'd2:    atom_sel = 2'd0;
            default: atom_sel = 2'd3;
        endcase
        key_pos  = rev_reg ? 2'd3 - atom_sel : atom_sel;
        is_outer = cmp_reg[1];
    end

    assign busy       = (state_reg != S_IDLE);
    assign lookup_go  = start && !busy && opcode == tpwl_pkg::OP_LOOKUP;
    assign q_load     = start && !busy;
    assign entry_idx  = ent_reg[tpwl_pkg::TIDX_W-1:0];
    assign macro_idx  = mac_reg[tpwl_pkg::MIDX_W-1:0];
    assign member_idx = mem_reg[tpwl_pkg::BIDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        pass_next  = pass_reg;
        rev_next   = rev_reg;
        cmp_next   = cmp_reg;
        mac_next   = mac_reg;
        mem_next   = mem_reg;
        hit_next   = hit_reg;
        cmd        = '0;
        cmd.key_sel = key_pos;
        cmp_ok     = 1'b0;
        cmp_fail   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (lookup_go)
                begin
                    ent_next   = '0;
                    pass_next  = 1'b0;
                    rev_next   = 1'b0;
                    cmp_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                if (ent_reg >= ncap)
                begin
                    if (pass_reg)
                        state_next = S_PARAM;
                    else
                    begin
                        pass_next = 1'b1;
                        ent_next  = '0;
                    end
                end
                else
                begin
                    cmd.key_rd = 1'b1;
                    mac_next   = '0;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                if (mac_reg >= mcap)
                begin
                    if (sts.plain_hit)
                        cmp_ok = 1'b1;
                    else
                        cmp_fail = 1'b1;
                end
                else
                begin
                    cmd.mac_rd = 1'b1;
                    mem_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mem_rd = 1'b1;
                mem_next   = '0;
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (!sts.name_hit)
                begin
                    mac_next   = mac_reg + 5'd1;
                    state_next = S_KEY;
                end
                else if (sts.is_univ && sts.univ_hit)
                    cmp_ok = 1'b1;
                else
                    state_next = S_MEM;
            end
            S_MEM:
            begin
                if (mem_reg >= scap)
                    cmp_fail = 1'b1;
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MEMCHK;
                end
            end
            S_MEMCHK:
            begin
                if (sts.mem_hit)
                    cmp_ok = 1'b1;
                else
                begin
                    mem_next   = mem_reg + 5'd1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_MEM;
            end
            S_PARAM:
            begin
                cmd.par_rd = 1'b1;
                cmd.clr    = !hit_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The member read for index mem_reg is issued in S_MEM; S_FETCH
        // simply returns there so the next member is read.
        if (cmp_fail && is_outer && pass_reg && sts.wild_ok)
        begin
            cmp_fail = 1'b0;
            cmp_ok   = 1'b1;
        end
        if (cmp_ok)
        begin
            if (cmp_reg == 2'd3)
            begin
                hit_next   = 1'b1;
                state_next = S_PARAM;
            end
            else
            begin
                cmp_next   = cmp_reg + 2'd1;
                state_next = S_ENTRY;
                cmd.key_rd = 1'b1;
                mac_next   = '0;
                state_next = S_KEY;
            end
        end
        else if (cmp_fail)
        begin
            cmp_next = '0;
            if (!rev_reg)
            begin
                rev_next   = 1'b1;
                state_next = S_ENTRY;
            end
            else
            begin
                rev_next   = 1'b0;
                ent_next   = ent_reg + 9'd1;
                state_next = S_ENTRY;
            end
        end
        if (cmd.key_rd && cmp_ok)
            cmd.key_sel = rev_reg ? 2'd3 - next_atom(cmp_reg + 2'd1)
                                  : next_atom(cmp_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ent_reg      <= '0;
            pass_reg     <= 1'b0;
            rev_reg      <= 1'b0;
            cmp_reg      <= '0;
            mac_reg      <= '0;
            mem_reg      <= '0;
            hit_reg      <= 1'b0;
            done         <= 1'b0;
            found        <= 1'b0;
            entry_number <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ent_reg   <= ent_next;
            pass_reg  <= pass_next;
            rev_reg   <= rev_next;
            cmp_reg   <= cmp_next;
            mac_reg   <= mac_next;
            mem_reg   <= mem_next;
            hit_reg   <= hit_next;
            done      <= cmd.emit;
            if (cmd.emit)
            begin
                found        <= hit_reg;
                entry_number <= hit_reg ? ent_reg + 9'd1 : 9'd0;
            end
        end
    end

endmodule

// ===== sv/torsion_param_wildcard_lookup_core.sv =====
// ----------------------------------------------------------------------------
// torsion_param_wildcard_lookup_core
// Torsion parameter table with wildcard and macro atom-type lookup.
// ----------------------------------------------------------------------------
// Loads give no result; busy stays low.
// A lookup walks the table keys, macros and members one compare at a time.
// The result strobe rises in the same cycle that busy falls; the receiver cannot stall.
// Reset clears control state and both count registers; stores are undefined until written.
module torsion_param_wildcard_lookup_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [7:0]         slot,
    input  logic [4:0]         count_or_member,
    input  logic [55:0]        name_a,
    input  logic [55:0]        name_b,
    input  logic [55:0]        name_c,
    input  logic [55:0]        name_d,
    input  logic signed [5:0]  mult_in,
    input  logic [31:0]        force_in,
    input  logic [31:0]        phase_in,
    input  logic [31:0]        term_in,
    input  logic               spare_flag,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               result_valid,
    output logic               found,
    output logic [8:0]         entry_number,
    output logic signed [5:0]  mult_out,
    output logic [31:0]        force_out,
    output logic [31:0]        phase_out,
    output logic [31:0]        term_out
);

    logic [8:0]                         entry_count_reg;
    logic [4:0]                         macro_count_reg;
    logic                               q_load;
    logic [tpwl_pkg::TIDX_W-1:0]        entry_idx;
    logic [1:0]                         atom_sel;
    logic [tpwl_pkg::MIDX_W-1:0]        macro_idx;
    logic [tpwl_pkg::BIDX_W-1:0]        member_idx;
    tpwl_pkg::tpwl_cmd_t                cmd;
    tpwl_pkg::tpwl_sts_t                sts;
    logic [4:0]                         size_w;
    logic                               unused_spare;

    assign cfg_ready    = 1'b1;
    assign unused_spare = spare_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            macro_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tpwl_pkg::CFG_ENTRY_COUNT)
                entry_count_reg <= cfg_data;
            else
                macro_count_reg <= cfg_data[4:0];
        end
    end

    tpwl_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .entry_count  (entry_count_reg),
        .macro_count  (macro_count_reg),
        .sts          (sts),
        .size_in      (size_w),
        .busy         (busy),
        .q_load       (q_load),
        .entry_idx    (entry_idx),
        .atom_sel     (atom_sel),
        .macro_idx    (macro_idx),
        .member_idx   (member_idx),
        .cmd          (cmd),
        .done         (result_valid),
        .found        (found),
        .entry_number (entry_number)
    );

    tpwl_datapath u_dp
    (
        .clk             (clk),
        .wr_en           (q_load),
        .opcode          (opcode),
        .slot            (slot),
        .count_or_member (count_or_member),
        .name_a          (name_a),
        .name_b          (name_b),
        .name_c          (name_c),
        .name_d          (name_d),
        .mult_in         (mult_in),
        .force_in        (force_in),
        .phase_in        (phase_in),
        .term_in         (term_in),
        .q_load          (q_load && opcode == tpwl_pkg::OP_LOOKUP),
        .entry_idx       (entry_idx),
        .atom_sel        (atom_sel),
        .macro_idx       (macro_idx),
        .member_idx      (member_idx),
        .cmd             (cmd),
        .sts             (sts),
        .size_out        (size_w),
        .mult_out        (mult_out),
        .force_out       (force_out),
        .phase_out       (phase_out),
        .term_out        (term_out)
    );

endmodule

// ===== sv/tpwl_checker.sv =====
// ----------------------------------------------------------------------------
// tpwl_checker
// Port-level checks for the torsion lookup core.
// ----------------------------------------------------------------------------
module tpwl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] opcode,
    input logic       result_valid,
    input logic       found,
    input logic [8:0] entry_number
);

    // A result beat only closes a search, so busy was high just before.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result without search");

    // The found flag and the entry number agree.
    a_found_number: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (found == (entry_number != 9'd0))) else $error("found mismatch");

    // Loads never raise busy.
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode != tpwl_pkg::OP_LOOKUP) |=> !busy)
        else $error("load made block busy");

    // A beat is one cycle long; busy falls with it and is low during the beat.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy) else $error("busy during result");

endmodule

bind torsion_param_wildcard_lookup_core tpwl_checker u_tpwl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .found        (found),
    .entry_number (entry_number)
);
